[rtl/swnc_pkg.sv]
package swnc_pkg;

  localparam int MAX_WALLS_DEF = 1024;
  localparam int COORD_W       = 32;
  localparam int DIFF_W        = 33;
  localparam int ZTOL_W        = 31;
  localparam int LIMB_W        = 34;
  localparam int MAG_W         = 2 * LIMB_W;
  localparam int ACC_W         = 4 * LIMB_W;
  localparam int DABS_W        = 104;
  localparam int Q_W           = 35;
  localparam int DIV_W         = MAG_W + Q_W - 1;
  localparam int WALL_W        = 6 * COORD_W;

  localparam logic [ZTOL_W-1:0] ZTOL_RST = 31'd65536;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  localparam logic [1:0] STS_DONE  = 2'd0;
  localparam logic [1:0] STS_FULL  = 2'd1;
  localparam logic [1:0] STS_QUERY = 2'd2;

  localparam logic REG_ZTOL = 1'b0;

  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
  } wv_t;

  typedef enum logic [3:0] {
    OP_ABX, OP_ABY, OP_DX, OP_DY, OP_AZS, OP_TN, OP_UN, OP_ZTOL, OP_BTN,
    OP_CDX, OP_CDY, OP_DEN, OP_DBZ, OP_DWZ, OP_BDEN, OP_DELTA
  } opnd_t;

  typedef enum logic [2:0] {
    P_DEN, P_TN, P_UN, P_DIFF, P_LIM, P_BEST, P_NUM
  } phase_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD, ST_WDIFF, ST_MAC, ST_CAP_DEN, ST_CAP_TN, ST_CAP_UN,
    ST_CAP_DIFF, ST_CHK_Z, ST_CHK_BEST, ST_NEXT, ST_DIV_GO, ST_DIV_WAIT, ST_DONE
  } state_t;

  typedef struct packed {
    opnd_t x;
    logic  xl;
    opnd_t y;
    logic  yl;
    logic  neg;
    logic  last;
  } uop_t;

  typedef struct packed {
    logic       en;
    logic       clear;
    logic       neg;
    logic [1:0] shift;
  } mac_ctl_t;

  function automatic logic [DIFF_W-1:0] sub33(logic [COORD_W-1:0] a, logic [COORD_W-1:0] b);
    return {a[COORD_W-1], a} - {b[COORD_W-1], b};
  endfunction

  function automatic wv_t to_wv(logic [DIFF_W-1:0] v);
    wv_t r;
    logic [DIFF_W-1:0] m;
    m = v[DIFF_W-1] ? (~v + DIFF_W'(1)) : v;
    r.neg = v[DIFF_W-1];
    r.mag = {{(MAG_W-DIFF_W){1'b0}}, m};
    return r;
  endfunction

  // micro-op table of the shared multiply-accumulate unit
  function automatic uop_t mac_uop(phase_t ph, logic [2:0] st);
    uop_t u;
    u.x = OP_ABX;
    u.xl = 1'b0;
    u.y = OP_CDY;
    u.yl = 1'b0;
    u.neg = 1'b0;
    u.last = 1'b0;
    case (ph)
      P_DEN, P_TN, P_UN: begin
        u.x = (ph == P_DEN) ? ((st == 3'd0) ? OP_ABX : OP_ABY) :
                              ((st == 3'd0) ? OP_DX : OP_DY);
        if (ph == P_UN) u.y = (st == 3'd0) ? OP_ABY : OP_ABX;
        else            u.y = (st == 3'd0) ? OP_CDY : OP_CDX;
        u.neg = (st != 3'd0);
        u.last = (st != 3'd0);
      end
      P_DIFF: begin
        case (st)
          3'd0, 3'd1: begin
            u.x = OP_AZS;
            u.y = OP_DEN;
            u.yl = st[0];
          end
          3'd2, 3'd3: begin
            u.x = OP_TN;
            u.xl = st[0];
            u.y = OP_DBZ;
          end
          default: begin
            u.x = OP_UN;
            u.xl = st[0];
            u.y = OP_DWZ;
            u.neg = 1'b1;
            u.last = st[0];
          end
        endcase
      end
      P_LIM: begin
        u.x = OP_ZTOL;
        u.y = OP_DEN;
        u.yl = st[0];
        u.last = st[0];
      end
      P_BEST: begin
        u.x = st[2] ? OP_BTN : OP_TN;
        u.y = st[2] ? OP_DEN : OP_BDEN;
        u.xl = st[1];
        u.yl = st[0];
        u.neg = st[2];
        u.last = (st == 3'd7);
      end
      default: begin
        u.x = OP_BTN;
        u.xl = st[0];
        u.y = OP_DELTA;
        u.last = st[0];
      end
    endcase
    return u;
  endfunction

endpackage

[rtl/swnc_wall_mem.sv]
module swnc_wall_mem #(
  parameter int DEPTH = swnc_pkg::MAX_WALLS_DEF,
  parameter int AW    = 10
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [swnc_pkg::WALL_W-1:0] wdata,
  input  logic                        re,
  input  logic [AW-1:0]               raddr,
  output logic [swnc_pkg::WALL_W-1:0] rdata
);
  import swnc_pkg::*;

  logic [WALL_W-1:0] mem [DEPTH];
  logic [WALL_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (re) rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/swnc_mac.sv]
module swnc_mac (
  input  logic                       clk,
  input  swnc_pkg::mac_ctl_t         ctl,
  input  logic [swnc_pkg::LIMB_W-1:0] a,
  input  logic [swnc_pkg::LIMB_W-1:0] b,
  output logic [swnc_pkg::ACC_W-1:0]  acc
);
  import swnc_pkg::*;

  logic [2*LIMB_W-1:0] prod;
  logic [ACC_W-1:0]    ext;
  logic [ACC_W-1:0]    addend;
  logic [ACC_W-1:0]    acc_r;
  logic [ACC_W-1:0]    acc_nxt;

  assign prod = a * b;

  always_comb begin
    case (ctl.shift)
      2'd0:    ext = ACC_W'(prod);
      2'd1:    ext = ACC_W'({prod, {LIMB_W{1'b0}}});
      default: ext = ACC_W'({prod, {(2*LIMB_W){1'b0}}});
    endcase
    addend = ctl.neg ? (~ext + ACC_W'(1)) : ext;
    acc_nxt = (ctl.clear ? '0 : acc_r) + addend;
  end

  always_ff @(posedge clk) begin
    if (ctl.en) acc_r <= acc_nxt;
  end

  assign acc = acc_r;

endmodule

[rtl/swnc_div.sv]
module swnc_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [swnc_pkg::DIV_W-1:0] num,
  input  logic [swnc_pkg::MAG_W-1:0] den,
  output logic                       done,
  output logic [swnc_pkg::Q_W-1:0]   quot
);
  import swnc_pkg::*;

  logic [DIV_W-1:0] rem_r;
  logic [DIV_W-1:0] sh_r;
  logic [Q_W-1:0]   q_r;
  logic [5:0]       cnt_r;
  logic             busy_r;
  logic             done_r;
  logic             ge;

  assign ge = (sh_r <= rem_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r <= 6'(Q_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num;
      sh_r <= {den, {(Q_W-1){1'b0}}};
      q_r <= '0;
    end else if (busy_r) begin
      if (ge) rem_r <= rem_r - sh_r;
      q_r <= {q_r[Q_W-2:0], ge};
      sh_r <= sh_r >> 1;
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

[rtl/segment_wall_nearest_crossing_top.sv]
// Nearest wall crossing finder.
// Input stream: tuser {ignore_z, cmd}, tdata {end_z, end_y, end_x, start_z, start_y,
// start_x}. cmd clear empties the wall table, append stores one wall, query walks every
// stored wall in order and reports the nearest XY crossing of the movement segment.
// Result stream: one transfer per input transfer, tuser {hit, status}, tdata
// {hit_z, hit_y, hit_x}.
// A query walks the stored walls and, when there is a hit, then computes the hit point.
// The per-wall work is done by the single 34x34 multiply-accumulate unit, which forms every
// cross product, height check and distance compare as a sequence of limb products; the hit
// point is formed by the bit-serial divider, one axis after another.
// One item at a time: in_tready is high only while the block is idle. A finished result
// sits in the output register; if the receiver stalls, the block may take the next
// item and hold its result until the output register is free.
// Reset empties the table and sets z_tolerance to 1.0; the APB register is at address 0.
module segment_wall_nearest_crossing_top #(
  parameter int MAX_WALLS = swnc_pkg::MAX_WALLS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [191:0] in_tdata,     // start_x, start_y, start_z, end_x, end_y, end_z
  input  logic [2:0]   in_tuser,     // cmd, ignore_z
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [95:0]  out_tdata,    // hit_x, hit_y, hit_z
  output logic [2:0]   out_tuser,    // status, hit
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);
  import swnc_pkg::*;

  localparam int CW = $clog2(MAX_WALLS + 1);
  localparam int AW = (MAX_WALLS > 1) ? $clog2(MAX_WALLS) : 1;

  state_t state_r, state_nxt;
  phase_t phase_r, phase_go;
  logic [2:0]  step_r;
  logic [CW-1:0] count_r, i_r;
  logic [1:0]  axis_r;
  logic        found_r;
  logic        out_valid_r;
  logic [ZTOL_W-1:0] z_tol_r;

  logic [COORD_W-1:0] ax_r, ay_r, az_r;
  wv_t abx_r, aby_r, dbz_r, cdx_r, cdy_r, dx_r, dy_r, azs_r, dwz_r;
  logic ign_r, den_neg_r, numneg_r;
  logic [MAG_W-1:0] den_r, tn_r, un_r, btn_r, bden_r;
  logic [DABS_W-1:0] dabs_r;
  logic [1:0] sts_r;
  logic [COORD_W-1:0] hx_r, hy_r, hz_r;
  logic [1:0] out_sts_r;
  logic out_hit_r;
  logic [COORD_W-1:0] out_hx_r, out_hy_r, out_hz_r;

  logic in_fire, q_go, mem_we, mem_re, full;
  logic [1:0] cmd;
  logic [WALL_W-1:0] rdata;
  logic [ACC_W-1:0] acc, acc_mag;
  logic acc_neg, acc_zero, tn_ok, un_ok, z_ok, cand, take, last_wall, out_free;
  uop_t uop;
  wv_t xo, yo;
  mac_ctl_t mac_ctl;
  logic div_start, div_done;
  logic [Q_W-1:0] quot;
  logic [COORD_W-1:0] off, base;

  assign cmd = in_tuser[1:0];
  assign in_fire = in_tvalid & in_tready;
  assign full = !(count_r < CW'(MAX_WALLS));
  assign q_go = (cmd == CMD_QUERY) && (count_r != '0) &&
                !((in_tdata[127:96] == in_tdata[31:0]) && (in_tdata[159:128] == in_tdata[63:32]));
  assign acc_neg = acc[ACC_W-1];
  assign acc_mag = acc_neg ? (~acc + ACC_W'(1)) : acc;
  assign acc_zero = (acc == '0);
  assign tn_ok = !acc_neg && !(acc_mag > ACC_W'(den_r));
  assign un_ok = tn_ok;
  assign z_ok = !(ACC_W'(dabs_r) > acc);
  assign cand = ((state_r == ST_CAP_UN) && un_ok && ign_r) || ((state_r == ST_CHK_Z) && z_ok);
  assign take = (cand && !found_r) || ((state_r == ST_CHK_BEST) && acc_neg);
  assign last_wall = ((i_r + CW'(1)) == count_r);
  assign out_free = !out_valid_r || out_tready;
  assign uop = mac_uop(phase_r, step_r);

  always_comb begin
    case (uop.x)
      OP_ABX:  xo = abx_r;
      OP_ABY:  xo = aby_r;
      OP_DX:   xo = dx_r;
      OP_DY:   xo = dy_r;
      OP_AZS:  xo = azs_r;
      OP_TN:   xo = '{neg: 1'b0, mag: tn_r};
      OP_UN:   xo = '{neg: 1'b0, mag: un_r};
      OP_ZTOL: xo = '{neg: 1'b0, mag: MAG_W'(z_tol_r)};
      OP_BTN:  xo = '{neg: 1'b0, mag: btn_r};
      default: xo = '0;
    endcase
  end

  always_comb begin
    case (uop.y)
      OP_CDX:  yo = cdx_r;
      OP_CDY:  yo = cdy_r;
      OP_ABX:  yo = abx_r;
      OP_ABY:  yo = aby_r;
      OP_DEN:  yo = '{neg: 1'b0, mag: den_r};
      OP_DBZ:  yo = dbz_r;
      OP_DWZ:  yo = dwz_r;
      OP_BDEN: yo = '{neg: 1'b0, mag: bden_r};
      OP_DELTA: yo = (axis_r == 2'd0) ? abx_r : ((axis_r == 2'd1) ? aby_r : dbz_r);
      default: yo = '0;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:     if (in_fire) state_nxt = q_go ? ST_RD : ST_DONE;
      ST_RD:       state_nxt = ST_WDIFF;
      ST_WDIFF:    state_nxt = ST_MAC;
      ST_MAC: begin
        if (uop.last) begin
          case (phase_r)
            P_DEN:   state_nxt = ST_CAP_DEN;
            P_TN:    state_nxt = ST_CAP_TN;
            P_UN:    state_nxt = ST_CAP_UN;
            P_DIFF:  state_nxt = ST_CAP_DIFF;
            P_LIM:   state_nxt = ST_CHK_Z;
            P_BEST:  state_nxt = ST_CHK_BEST;
            default: state_nxt = ST_DIV_GO;
          endcase
        end
      end
      ST_CAP_DEN:  state_nxt = acc_zero ? ST_NEXT : ST_MAC;
      ST_CAP_TN:   state_nxt = tn_ok ? ST_MAC : ST_NEXT;
      ST_CAP_UN: begin
        if (!un_ok) state_nxt = ST_NEXT;
        else if (!ign_r || found_r) state_nxt = ST_MAC;
        else state_nxt = ST_NEXT;
      end
      ST_CAP_DIFF: state_nxt = ST_MAC;
      ST_CHK_Z:    state_nxt = (z_ok && found_r) ? ST_MAC : ST_NEXT;
      ST_CHK_BEST: state_nxt = ST_NEXT;
      ST_NEXT: begin
        if (!last_wall) state_nxt = ST_RD;
        else state_nxt = found_r ? ST_MAC : ST_DONE;
      end
      ST_DIV_GO:   state_nxt = ST_DIV_WAIT;
      ST_DIV_WAIT: if (div_done) state_nxt = (axis_r == 2'd2) ? ST_DONE : ST_MAC;
      ST_DONE:     if (out_free) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // outputs to the shared units and memory
  always_comb begin
    in_tready = (state_r == ST_IDLE);
    mem_we = in_fire && (cmd == CMD_APPEND) && !full;
    mem_re = (state_r == ST_RD);
    div_start = (state_r == ST_DIV_GO);
    mac_ctl.en = (state_r == ST_MAC);
    mac_ctl.clear = (step_r == 3'd0);
    mac_ctl.shift = 2'(uop.xl) + 2'(uop.yl);
    mac_ctl.neg = xo.neg ^ yo.neg ^ uop.neg ^
                  (((phase_r == P_TN) || (phase_r == P_UN)) & den_neg_r);
    case (state_r)
      ST_WDIFF:    phase_go = P_DEN;
      ST_CAP_DEN:  phase_go = P_TN;
      ST_CAP_TN:   phase_go = P_UN;
      ST_CAP_UN:   phase_go = ign_r ? P_BEST : P_DIFF;
      ST_CAP_DIFF: phase_go = P_LIM;
      ST_CHK_Z:    phase_go = P_BEST;
      default:     phase_go = P_NUM;
    endcase
  end

  swnc_wall_mem #(.DEPTH(MAX_WALLS), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (count_r[AW-1:0]),
    .wdata (in_tdata),
    .re    (mem_re),
    .raddr (i_r[AW-1:0]),
    .rdata (rdata)
  );

  swnc_mac u_mac (
    .clk (clk),
    .ctl (mac_ctl),
    .a   (uop.xl ? xo.mag[MAG_W-1:LIMB_W] : xo.mag[LIMB_W-1:0]),
    .b   (uop.yl ? yo.mag[MAG_W-1:LIMB_W] : yo.mag[LIMB_W-1:0]),
    .acc (acc)
  );

  swnc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (acc_mag[DIV_W-1:0]),
    .den   (bden_r),
    .done  (div_done),
    .quot  (quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      phase_r <= P_DEN;
      step_r <= '0;
      count_r <= '0;
      i_r <= '0;
      axis_r <= '0;
      found_r <= 1'b0;
      out_valid_r <= 1'b0;
      z_tol_r <= ZTOL_RST;
    end else begin
      state_r <= state_nxt;
      if (cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr[2] == REG_ZTOL))
        z_tol_r <= cfg_pwdata[ZTOL_W-1:0];
      if (state_r == ST_MAC) step_r <= step_r + 3'd1;
      else if (state_nxt == ST_MAC) begin
        step_r <= '0;
        phase_r <= phase_go;
      end
      if (in_fire) begin
        found_r <= 1'b0;
        i_r <= '0;
        if (cmd == CMD_CLEAR) count_r <= '0;
        else if (mem_we) count_r <= count_r + CW'(1);
      end
      if (take) found_r <= 1'b1;
      if (state_r == ST_NEXT) begin
        i_r <= i_r + CW'(1);
        axis_r <= '0;
      end
      if ((state_r == ST_DIV_WAIT) && div_done) axis_r <= axis_r + 2'd1;
      if ((state_r == ST_DONE) && out_free) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  assign off = numneg_r ? (~quot[COORD_W-1:0] + COORD_W'(1)) : quot[COORD_W-1:0];
  assign base = (axis_r == 2'd0) ? ax_r : ((axis_r == 2'd1) ? ay_r : az_r);

  always_ff @(posedge clk) begin
    if (in_fire) begin
      ax_r <= in_tdata[31:0];
      ay_r <= in_tdata[63:32];
      az_r <= in_tdata[95:64];
      abx_r <= to_wv(sub33(in_tdata[127:96], in_tdata[31:0]));
      aby_r <= to_wv(sub33(in_tdata[159:128], in_tdata[63:32]));
      dbz_r <= to_wv(sub33(in_tdata[191:160], in_tdata[95:64]));
      ign_r <= in_tuser[2];
      hx_r <= '0;
      hy_r <= '0;
      hz_r <= '0;
      if (cmd == CMD_QUERY) sts_r <= STS_QUERY;
      else if ((cmd == CMD_APPEND) && full) sts_r <= STS_FULL;
      else sts_r <= STS_DONE;
    end
    if (state_r == ST_WDIFF) begin
      cdx_r <= to_wv(sub33(rdata[127:96], rdata[31:0]));
      cdy_r <= to_wv(sub33(rdata[159:128], rdata[63:32]));
      dx_r <= to_wv(sub33(rdata[31:0], ax_r));
      dy_r <= to_wv(sub33(rdata[63:32], ay_r));
      azs_r <= to_wv(sub33(az_r, rdata[95:64]));
      dwz_r <= to_wv(sub33(rdata[191:160], rdata[95:64]));
    end
    if (state_r == ST_CAP_DEN) begin
      den_r <= acc_mag[MAG_W-1:0];
      den_neg_r <= acc_neg;
    end
    if (state_r == ST_CAP_TN) tn_r <= acc_mag[MAG_W-1:0];
    if (state_r == ST_CAP_UN) un_r <= acc_mag[MAG_W-1:0];
    if (state_r == ST_CAP_DIFF) dabs_r <= acc_mag[DABS_W-1:0];
    if (take) begin
      btn_r <= tn_r;
      bden_r <= den_r;
    end
    if (state_r == ST_DIV_GO) numneg_r <= acc_neg;
    if ((state_r == ST_DIV_WAIT) && div_done) begin
      case (axis_r)
        2'd0:    hx_r <= base + off;
        2'd1:    hy_r <= base + off;
        default: hz_r <= base + off;
      endcase
    end
    if ((state_r == ST_DONE) && out_free) begin
      out_sts_r <= sts_r;
      out_hit_r <= found_r;
      out_hx_r <= hx_r;
      out_hy_r <= hy_r;
      out_hz_r <= hz_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = {out_hz_r, out_hy_r, out_hx_r};
  assign out_tuser = {out_hit_r, out_sts_r};
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_ZTOL) ? {1'b0, z_tol_r} : '0;

endmodule

[rtl/swnc_check.sv]
module swnc_check (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [95:0] out_tdata,
  input logic [2:0]  out_tuser
);

  // busy after every accepted transfer
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while busy");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // results other than query results carry no hit and no point
  a_nonquery: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[1:0] != 2'd2) |-> !out_tuser[2] && (out_tdata == '0))
    else $error("non-query result with hit data");

  a_nohit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[2] |-> (out_tdata == '0) && (out_tuser[1:0] != 2'd3))
    else $error("miss with nonzero point");

endmodule

bind segment_wall_nearest_crossing_top swnc_check u_swnc_check (.*);

[sim/swnc_checker.sv]
`timescale 1ns / 1ps

module swnc_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [191:0] in_tdata,
  input  logic [2:0]   in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [95:0]  out_tdata,
  input  logic [2:0]   out_tuser,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic         cfg_pready,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output int           errors,
  output int           results_owed,
  output int           hits_seen,
  output int           results_seen
);
  import swnc_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic        hit;
    logic [31:0] hit_x;
    logic [31:0] hit_y;
    logic [31:0] hit_z;
  } crossing_t;

  typedef logic signed [159:0] wide_t;

  logic [31:0] wsx [MAX_WALLS_DEF];
  logic [31:0] wsy [MAX_WALLS_DEF];
  logic [31:0] wsz [MAX_WALLS_DEF];
  logic [31:0] wex [MAX_WALLS_DEF];
  logic [31:0] wey [MAX_WALLS_DEF];
  logic [31:0] wez [MAX_WALLS_DEF];
  int          wall_cnt;
  logic [ZTOL_W-1:0] ztol;
  crossing_t   crossing_q[$];

  function automatic wide_t wide(logic [31:0] v);
    wide_t r;
    r = $signed(v);
    return r;
  endfunction

  function automatic crossing_t nearest_crossing(logic [191:0] d, logic [2:0] u);
    crossing_t r;
    wide_t ax, ay, az, abx, aby, dbz, sx, sy, sz, cdx, cdy, dx, dy, dwz;
    wide_t den, tn, un, diff, lim, btn, bden;
    logic  found;
    r = '0;
    found = 1'b0;
    btn = 0;
    bden = 1;
    case (u[1:0])
      CMD_CLEAR: wall_cnt = 0;
      CMD_APPEND: begin
        if (wall_cnt < MAX_WALLS_DEF) begin
          wsx[wall_cnt] = d[31:0];
          wsy[wall_cnt] = d[63:32];
          wsz[wall_cnt] = d[95:64];
          wex[wall_cnt] = d[127:96];
          wey[wall_cnt] = d[159:128];
          wez[wall_cnt] = d[191:160];
          wall_cnt++;
        end else begin
          r.status = STS_FULL;
        end
      end
      CMD_QUERY: begin
        r.status = STS_QUERY;
        ax = wide(d[31:0]);
        ay = wide(d[63:32]);
        az = wide(d[95:64]);
        abx = wide(d[127:96]) - ax;
        aby = wide(d[159:128]) - ay;
        dbz = wide(d[191:160]) - az;
        if (abx != 0 || aby != 0) begin
          for (int i = 0; i < wall_cnt; i++) begin
            sx = wide(wsx[i]);
            sy = wide(wsy[i]);
            sz = wide(wsz[i]);
            cdx = wide(wex[i]) - sx;
            cdy = wide(wey[i]) - sy;
            dwz = wide(wez[i]) - sz;
            dx = sx - ax;
            dy = sy - ay;
            den = abx * cdy - aby * cdx;
            if (den == 0) continue;
            tn = dx * cdy - dy * cdx;
            un = dx * aby - dy * abx;
            if (den < 0) begin
              den = -den;
              tn = -tn;
              un = -un;
            end
            if (tn < 0 || un < 0 || tn > den || un > den) continue;
            if (!u[2]) begin
              diff = (az - sz) * den + tn * dbz - un * dwz;
              if (diff < 0) diff = -diff;
              lim = wide_t'({129'd0, ztol}) * den;
              if (diff > lim) continue;
            end
            if (!found || tn * bden < btn * den) begin
              btn = tn;
              bden = den;
              found = 1'b1;
            end
          end
        end
        if (found) begin
          r.hit = 1'b1;
          r.hit_x = 32'(ax + (btn * abx) / bden);
          r.hit_y = 32'(ay + (btn * aby) / bden);
          r.hit_z = 32'(az + (btn * dbz) / bden);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    crossing_t got, want;
    if (!rst_n) begin
      wall_cnt = 0;
      ztol = ZTOL_RST;
      crossing_q.delete();
      errors <= 0;
      results_owed <= 0;
      hits_seen <= 0;
      results_seen <= 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr == {REG_ZTOL, 2'b00})
        ztol = cfg_pwdata[ZTOL_W-1:0];
      if (in_tvalid && in_tready)
        crossing_q.push_back(nearest_crossing(in_tdata, in_tuser));
      if (out_tvalid && out_tready) begin
        got = {out_tuser[1:0], out_tuser[2], out_tdata[31:0], out_tdata[63:32], out_tdata[95:64]};
        results_seen <= results_seen + 1;
        if (got.hit) hits_seen <= hits_seen + 1;
        if (crossing_q.size() == 0) begin
          $display("%0t: unexpected result transfer sts=%0d hit=%0b", $time, got.status,
                   got.hit);
          errors <= errors + 1;
        end else begin
          want = crossing_q.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch exp sts=%0d hit=%0b x=%h y=%h z=%h", $time, want.status,
                     want.hit, want.hit_x, want.hit_y, want.hit_z);
            $display("%0t:          got sts=%0d hit=%0b x=%h y=%h z=%h", $time, got.status,
                     got.hit, got.hit_x, got.hit_y, got.hit_z);
            errors <= errors + 1;
          end
        end
      end
      results_owed <= crossing_q.size();
    end
  end

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps

module tb;
  import swnc_pkg::*;

  localparam int  ONE   = 65536;
  localparam int  LIMIT = 3000000;
  localparam logic [1:0] CMD_SPARE = 2'd3;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [191:0] in_tdata = '0;     // start_x, start_y, start_z, end_x, end_y, end_z
  logic [2:0]   in_tuser = '0;     // cmd, ignore_z
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [95:0]  out_tdata;         // hit_x, hit_y, hit_z
  logic [2:0]   out_tuser;         // status, hit
  logic         cfg_psel = 1'b0;
  logic         cfg_penable = 1'b0;
  logic         cfg_pwrite = 1'b0;
  logic [2:0]   cfg_paddr = '0;
  logic [31:0]  cfg_pwdata = '0;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  int   errors, results_owed, hits_seen, results_seen;
  int   send_pct = 0;
  int   stall_pct = 0;
  int   hold_cnt = 0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;
  int   cycles = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  segment_wall_nearest_crossing_top i_dut (.*);

  swnc_checker i_checker (.*);

  // receiver with one long hold-off on request
  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_cnt <= 400;
      out_tready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  function automatic logic [31:0] coord(int span);
    if ($urandom_range(9) == 0) return $urandom;
    return 32'($urandom_range(0, 2 * span)) - 32'(span);
  endfunction

  task automatic send(logic [1:0] cmd, logic [31:0] sx, sy, sz, ex, ey, ez, logic ign);
    in_tvalid <= 1'b1;
    in_tdata <= {ez, ey, ex, sz, sy, sx};
    in_tuser <= {ign, cmd};
    do @(posedge clk); while (!in_tready);
    if ($urandom_range(99) < send_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic send_rand(logic [1:0] cmd);
    send(cmd, coord(10 * ONE), coord(10 * ONE), coord(2 * ONE), coord(10 * ONE),
         coord(10 * ONE), coord(2 * ONE), 1'($urandom_range(1)));
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_batch(int n);
    int pick;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      if (pick < 8) send_rand(CMD_CLEAR);
      else if (pick < 53) send_rand(CMD_APPEND);
      else if (pick < 93) send_rand(CMD_QUERY);
      else send_rand(CMD_SPARE);
    end
  endtask

  initial begin
    logic [31:0] ztol_set [4];
    ztol_set = '{32'd0, 32'h7fff_ffff, 32'(ONE / 2), 32'(ONE)};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed
    send(CMD_QUERY, -5 * ONE, 0, 0, 5 * ONE, 0, 0, 1'b0);
    send(CMD_APPEND, 0, -5 * ONE, 0, 0, 5 * ONE, 0, 1'b1);
    send(CMD_APPEND, 2 * ONE, -5 * ONE, 0, 2 * ONE, 5 * ONE, 0, 1'b0);
    send(CMD_APPEND, ONE, ONE, 0, ONE, ONE, 5 * ONE, 1'b0);
    send(CMD_APPEND, -5 * ONE, 7 * ONE, 0, 5 * ONE, 7 * ONE, 0, 1'b0);
    send(CMD_QUERY, -5 * ONE, 0, 0, 5 * ONE, 0, 0, 1'b0);
    send(CMD_QUERY, 5 * ONE, 0, 0, -5 * ONE, 0, 0, 1'b0);
    send(CMD_QUERY, ONE, ONE, 0, ONE, ONE, 0, 1'b0);
    send(CMD_QUERY, -5 * ONE, 0, 10 * ONE, 5 * ONE, 0, 10 * ONE, 1'b0);
    send(CMD_QUERY, -5 * ONE, 0, 10 * ONE, 5 * ONE, 0, 10 * ONE, 1'b1);
    send(CMD_QUERY, -5 * ONE, 5 * ONE, 0, 5 * ONE, 5 * ONE, 0, 1'b0);
    send(CMD_QUERY, -5 * ONE, 0, 3, 0, 0, -7, 1'b0);
    send(CMD_APPEND, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
         32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
    send(CMD_QUERY, 32'h7fff_ffff, 32'h8000_0000, 0, 32'h8000_0000, 32'h7fff_ffff, 0, 1'b1);
    send(CMD_QUERY, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
         32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
    send(CMD_SPARE, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 1'b1);
    send(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 1'b1);
    send(CMD_QUERY, -5 * ONE, 0, 0, 5 * ONE, 0, 0, 1'b1);
    send(CMD_APPEND, 0, -5 * ONE, 0, 0, 5 * ONE, 0, 1'b0);
    send(CMD_APPEND, 0, 5 * ONE, ONE, 0, -5 * ONE, ONE, 1'b0);
    send(CMD_QUERY, -5 * ONE, 0, 0, 5 * ONE, 0, ONE, 1'b0);
    drain();

    // random phases, each with its own tolerance and idling mix
    for (int ph = 0; ph < 4; ph++) begin
      apb_write({REG_ZTOL, 2'b00}, ztol_set[ph]);
      apb_write(3'd4, $urandom);
      send_pct = (ph == 1) ? 59 : (ph == 3) ? 34 : 0;
      stall_pct = (ph == 2) ? 59 : (ph == 3) ? 34 : 0;
      if (ph == 0) hold_req <= 1'b1;
      random_batch(25);
      drain();
    end
    apb_write({REG_ZTOL, 2'b00}, 32'($urandom_range(0, 3 * ONE)));
    random_batch(20);
    drain();
    repeat (200) @(posedge clk);

    $display("tb: %0d results checked, %0d with a crossing", results_seen, hits_seen);
    $display("tb: four tolerances and idling mixes, long output hold-off, edge coordinates");
    if (errors == 0 && results_owed == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
